@@ design/cfir_pkg.sv @@
`timescale 1ns / 1ps

package cfir_pkg;

  // Sizes of the filter.
  localparam int MAX_TAPS     = 64;
  localparam int SAMPLE_WIDTH = 16;
  localparam int ACC_WIDTH    = 40;
  localparam int PROD_WIDTH   = 2 * SAMPLE_WIDTH + 1;

  // Field widths.
  localparam int FUNC_W    = 2;
  localparam int TAP_IDX_W = 6;
  localparam int TAP_CNT_W = 7;
  localparam int SHIFT_W   = 5;

  // Configuration port.
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 8;
  localparam logic [CFG_IDX_W-1:0] CFG_TAP_COUNT    = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] CFG_OUTPUT_SHIFT = CFG_IDX_W'(1);

  // Register values after reset.
  localparam logic [TAP_CNT_W-1:0] TAP_COUNT_RST    = TAP_CNT_W'(64);
  localparam logic [SHIFT_W-1:0]   OUTPUT_SHIFT_RST = SHIFT_W'(15);

  // Request kinds.
  localparam logic [FUNC_W-1:0] FUNC_SAMPLE = FUNC_W'(0);
  localparam logic [FUNC_W-1:0] FUNC_TAP    = FUNC_W'(1);
  localparam logic [FUNC_W-1:0] FUNC_CLEAR  = FUNC_W'(2);

  // Accumulation sweep: the products are formed, then the partial sum passes each cell in turn.
  localparam int CNT_W = $clog2(MAX_TAPS + 2);
  localparam logic [CNT_W-1:0] CALC_LAST = CNT_W'(MAX_TAPS + 1);

  // Saturation bounds, held at accumulator width.
  localparam logic signed [ACC_WIDTH-1:0] SAT_MAX =
    (ACC_WIDTH'(1) <<< (SAMPLE_WIDTH - 1)) - ACC_WIDTH'(1);
  localparam logic signed [ACC_WIDTH-1:0] SAT_MIN = ~SAT_MAX;

  typedef struct packed {
    logic [FUNC_W-1:0]              func;
    logic signed [SAMPLE_WIDTH-1:0] sample_re;
    logic signed [SAMPLE_WIDTH-1:0] sample_im;
    logic [TAP_IDX_W-1:0]           tap_index;
    logic signed [SAMPLE_WIDTH-1:0] tap_re;
    logic signed [SAMPLE_WIDTH-1:0] tap_im;
  } in_t;

  typedef struct packed {
    logic signed [SAMPLE_WIDTH-1:0] out_re;
    logic signed [SAMPLE_WIDTH-1:0] out_im;
  } out_t;

  typedef struct packed {
    logic signed [SAMPLE_WIDTH-1:0] re;
    logic signed [SAMPLE_WIDTH-1:0] im;
  } cplx_t;

  typedef struct packed {
    logic signed [ACC_WIDTH-1:0] re;
    logic signed [ACC_WIDTH-1:0] im;
  } acc_t;

  // Per-cell control.
  typedef struct packed {
    logic shift;
    logic clear;
    logic coef_we;
    logic tap_en;
  } cell_ctl_t;

  typedef enum logic {
    ST_IDLE,
    ST_CALC
  } state_t;

  // Floor shift of the accumulator, then saturation to sample width.
  function automatic logic signed [SAMPLE_WIDTH-1:0] shift_sat(
    input logic signed [ACC_WIDTH-1:0] acc,
    input logic [SHIFT_W-1:0]          sh
  );
    logic signed [ACC_WIDTH-1:0] v;
    v = acc >>> sh;
    if (v > SAT_MAX) begin
      return SAT_MAX[SAMPLE_WIDTH-1:0];
    end else if (v < SAT_MIN) begin
      return SAT_MIN[SAMPLE_WIDTH-1:0];
    end
    return v[SAMPLE_WIDTH-1:0];
  endfunction

endpackage

@@ design/complex_fir_filter.sv @@
`timescale 1ns / 1ps
// A sample request forms the cell products, sweeps the partial sum along the 64 cells and then
// scales it; no further request is taken until its result is in the output register.
// Tap writes and clears start no sweep, so the filter stays ready for the next request.
// A finished result waits in the output register while the next request is taken.
// Reset clears the delay line and all coefficients, sets tap_count to 64 and output_shift to 15.

module complex_fir_filter (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_valid,
  output logic                              in_ready,
  input  cfir_pkg::in_t                     in_data,
  output logic                              out_valid,
  input  logic                              out_ready,
  output cfir_pkg::out_t                    out_data,
  input  logic                              cfg_valid,
  output logic                              cfg_ready,
  input  logic [cfir_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [cfir_pkg::CFG_DATA_W-1:0]   cfg_data
);

  cfir_pkg::state_t state_r, state_nxt;
  logic [cfir_pkg::CNT_W-1:0] cnt_r, cnt_nxt;
  logic out_valid_r, out_valid_nxt;
  logic out_load;
  cfir_pkg::out_t out_r;
  logic [cfir_pkg::TAP_CNT_W-1:0] tap_count_r;
  logic [cfir_pkg::SHIFT_W-1:0]   shift_r;

  logic in_acc;
  logic do_shift, do_clear, do_tap;
  cfir_pkg::cplx_t new_sample, new_coef;
  cfir_pkg::cplx_t   x_link    [cfir_pkg::MAX_TAPS];
  cfir_pkg::acc_t    psum_link [cfir_pkg::MAX_TAPS];
  cfir_pkg::cell_ctl_t ctl     [cfir_pkg::MAX_TAPS];
  cfir_pkg::acc_t    total;

  assign in_ready  = (state_r == cfir_pkg::ST_IDLE);
  assign in_acc    = in_valid && in_ready;
  assign cfg_ready = 1'b1;

  // Request decode; the unused code does nothing.
  assign do_shift = in_acc && (in_data.func == cfir_pkg::FUNC_SAMPLE);
  assign do_tap   = in_acc && (in_data.func == cfir_pkg::FUNC_TAP);
  assign do_clear = in_acc && (in_data.func == cfir_pkg::FUNC_CLEAR);

  assign new_sample.re = in_data.sample_re;
  assign new_sample.im = in_data.sample_im;
  assign new_coef.re   = in_data.tap_re;
  assign new_coef.im   = in_data.tap_im;

  // Row of tap cells: samples move toward higher index, sums follow them.
  for (genvar k = 0; k < cfir_pkg::MAX_TAPS; k++) begin : g_cell
    assign ctl[k].shift   = do_shift;
    assign ctl[k].clear   = do_clear;
    assign ctl[k].coef_we = do_tap && (in_data.tap_index == cfir_pkg::TAP_IDX_W'(k));
    assign ctl[k].tap_en  = (tap_count_r > cfir_pkg::TAP_CNT_W'(k));

    if (k == 0) begin : g_head
      cfir_cell u_cell (
        .clk      (clk),
        .rst_n    (rst_n),
        .ctl      (ctl[k]),
        .x_in     (new_sample),
        .x_out    (x_link[k]),
        .coef_in  (new_coef),
        .psum_in  ('0),
        .psum_out (psum_link[k])
      );
    end else begin : g_body
      cfir_cell u_cell (
        .clk      (clk),
        .rst_n    (rst_n),
        .ctl      (ctl[k]),
        .x_in     (x_link[k-1]),
        .x_out    (x_link[k]),
        .coef_in  (new_coef),
        .psum_in  (psum_link[k-1]),
        .psum_out (psum_link[k])
      );
    end
  end

  assign total = psum_link[cfir_pkg::MAX_TAPS-1];

  // Sequencer: count the sweep, then load the output when it is free.
  always_comb begin
    state_nxt     = state_r;
    cnt_nxt       = cnt_r;
    out_load      = 1'b0;
    out_valid_nxt = out_valid_r;
    if (out_valid_r && out_ready) begin
      out_valid_nxt = 1'b0;
    end
    case (state_r)
      cfir_pkg::ST_IDLE: begin
        cnt_nxt = '0;
        if (do_shift) begin
          state_nxt = cfir_pkg::ST_CALC;
        end
      end
      cfir_pkg::ST_CALC: begin
        if (cnt_r == cfir_pkg::CALC_LAST) begin
          if (!out_valid_r || out_ready) begin
            out_load      = 1'b1;
            out_valid_nxt = 1'b1;
            state_nxt     = cfir_pkg::ST_IDLE;
          end
        end else begin
          cnt_nxt = cnt_r + cfir_pkg::CNT_W'(1);
        end
      end
      default: begin
        state_nxt = cfir_pkg::ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= cfir_pkg::ST_IDLE;
      cnt_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      cnt_r       <= cnt_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Output register: scale and saturate the finished sums.
  always_ff @(posedge clk) begin
    if (out_load) begin
      out_r.out_re <= cfir_pkg::shift_sat(total.re, shift_r);
      out_r.out_im <= cfir_pkg::shift_sat(total.im, shift_r);
    end
  end

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tap_count_r <= cfir_pkg::TAP_COUNT_RST;
      shift_r     <= cfir_pkg::OUTPUT_SHIFT_RST;
    end else if (cfg_valid && cfg_ready) begin
      if (cfg_index == cfir_pkg::CFG_TAP_COUNT) begin
        tap_count_r <= cfg_data[cfir_pkg::TAP_CNT_W-1:0];
      end else if (cfg_index == cfir_pkg::CFG_OUTPUT_SHIFT) begin
        shift_r <= cfg_data[cfir_pkg::SHIFT_W-1:0];
      end
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_r;

endmodule

@@ design/cfir_cell.sv @@
`timescale 1ns / 1ps

module cfir_cell (
  input  logic               clk,
  input  logic               rst_n,
  input  cfir_pkg::cell_ctl_t ctl,
  input  cfir_pkg::cplx_t    x_in,
  output cfir_pkg::cplx_t    x_out,
  input  cfir_pkg::cplx_t    coef_in,
  input  cfir_pkg::acc_t     psum_in,
  output cfir_pkg::acc_t     psum_out
);

  cfir_pkg::cplx_t x_r;
  cfir_pkg::cplx_t coef_r;
  logic signed [cfir_pkg::PROD_WIDTH-1:0] prod_re_r;
  logic signed [cfir_pkg::PROD_WIDTH-1:0] prod_im_r;
  logic signed [cfir_pkg::PROD_WIDTH-1:0] prod_re_nxt;
  logic signed [cfir_pkg::PROD_WIDTH-1:0] prod_im_nxt;
  logic signed [2*cfir_pkg::SAMPLE_WIDTH-1:0] p_rr, p_ii, p_ri, p_ir;
  cfir_pkg::acc_t psum_r;
  cfir_pkg::acc_t psum_nxt;

  // Delay tap and coefficient held by this cell.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      x_r    <= '0;
      coef_r <= '0;
    end else begin
      if (ctl.clear) begin
        x_r <= '0;
      end else if (ctl.shift) begin
        x_r <= x_in;
      end
      if (ctl.coef_we) begin
        coef_r <= coef_in;
      end
    end
  end

  // Complex product of the tap and the held sample.
  always_comb begin
    p_rr = coef_r.re * x_r.re;
    p_ii = coef_r.im * x_r.im;
    p_ri = coef_r.re * x_r.im;
    p_ir = coef_r.im * x_r.re;
    prod_re_nxt = cfir_pkg::PROD_WIDTH'(p_rr) - cfir_pkg::PROD_WIDTH'(p_ii);
    prod_im_nxt = cfir_pkg::PROD_WIDTH'(p_ri) + cfir_pkg::PROD_WIDTH'(p_ir);
  end

  // Partial sum moves one cell on per cycle; unused taps pass it unchanged.
  always_comb begin
    psum_nxt = psum_in;
    if (ctl.tap_en) begin
      psum_nxt.re = psum_in.re + cfir_pkg::ACC_WIDTH'(prod_re_r);
      psum_nxt.im = psum_in.im + cfir_pkg::ACC_WIDTH'(prod_im_r);
    end
  end

  always_ff @(posedge clk) begin
    prod_re_r <= prod_re_nxt;
    prod_im_r <= prod_im_nxt;
    psum_r    <= psum_nxt;
  end

  assign x_out    = x_r;
  assign psum_out = psum_r;

endmodule
